// ===== rtl/core/dpoc_pkg.sv =====
`default_nettype none

package dpoc_pkg;

  localparam int CMD_W = 2;
  localparam int SYM_W = 8;
  localparam int CNT_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic             match;
    logic [CNT_W-1:0] occurrences;
    logic             final_res;
    logic             error;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/dpoc_table.sv =====
`default_nettype none

module dpoc_table #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 7
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // The read data holds until the next read, so a stalled consumer sees it unchanged.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/dpoc_ctrl.sv =====
`default_nettype none

module dpoc_ctrl #(
  parameter int MAX_PATTERN   = 64,
  parameter int ALPHABET_SIZE = 256,
  parameter int SVW           = 7,
  parameter int AW            = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [dpoc_pkg::CMD_W-1:0] command_i,
  input  logic [dpoc_pkg::SYM_W-1:0] symbol_i,
  input  logic                       last_of_text_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output dpoc_pkg::res_t             res_o,
  output logic                       mem_rd_en_o,
  output logic [AW-1:0]              mem_rd_addr_o,
  input  logic [SVW-1:0]             mem_rd_data_i,
  output logic                       mem_wr_en_o,
  output logic [AW-1:0]              mem_wr_addr_o,
  output logic [SVW-1:0]             mem_wr_data_o
);

  import dpoc_pkg::*;

  localparam int RW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CW = $clog2(ALPHABET_SIZE);
  localparam int KW = $clog2(ALPHABET_SIZE + 1);

  localparam logic [AW-1:0]  ROW_STRIDE = AW'(ALPHABET_SIZE);
  localparam logic [KW-1:0]  SWEEP_END  = KW'(ALPHABET_SIZE);
  localparam logic [SVW-1:0] LEN_FULL   = SVW'(MAX_PATTERN);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SWEEP,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [SVW-1:0]   len_q, len_d;
  logic [RW-1:0]    fb_q, fb_d;
  logic [RW-1:0]    fbn_q, fbn_d;
  logic [RW-1:0]    ms_q, ms_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SYM_W-1:0] sym_q, sym_d;
  logic             sym_ok_q, sym_ok_d;
  logic             last_q, last_d;
  logic [KW-1:0]    k_q, k_d;
  res_t             res_q, res_d;

  logic             in_alpha;
  logic [RW-1:0]    rd_row, wr_row;
  logic [CW-1:0]    rd_col, wr_col;
  logic [SVW-1:0]   ns;
  logic             hit;
  logic [CNT_W-1:0] cnt_inc;

  assign in_alpha   = ({{(32 - SYM_W){1'b0}}, symbol_i} < 32'(ALPHABET_SIZE));
  assign in_ready_o = (state_q == ST_IDLE);

  // Text step: the row of the current state was read in the accept cycle.
  assign ns      = ((len_q != '0) && sym_ok_q) ? mem_rd_data_i : '0;
  assign hit     = (len_q != '0) && (ns >= len_q);
  assign cnt_inc = (hit && (cnt_q != CNT_MAX)) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    state_d       = state_q;
    len_d         = len_q;
    fb_d          = fb_q;
    fbn_d         = fbn_q;
    ms_d          = ms_q;
    cnt_d         = cnt_q;
    sym_d         = sym_q;
    sym_ok_d      = sym_ok_q;
    last_d        = last_q;
    k_d           = k_q;
    res_d         = res_q;
    mem_rd_en_o   = 1'b0;
    rd_row        = ms_q;
    rd_col        = CW'(symbol_i);
    mem_wr_en_o   = 1'b0;
    wr_row        = RW'(len_q);
    wr_col        = CW'(k_q - 1'b1);
    mem_wr_data_o = '0;
    res_valid_o   = 1'b0;
    res_o         = res_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sym_d    = symbol_i;
          sym_ok_d = in_alpha;
          last_d   = last_of_text_i;
          unique case (cmd_e'(command_i))
            CMD_CLEAR: begin
              len_d   = '0;
              fb_d    = '0;
              ms_d    = '0;
              cnt_d   = '0;
              res_d   = '0;
              state_d = ST_DONE;
            end
            CMD_APPEND: begin
              if ((len_q == LEN_FULL) || !in_alpha) begin
                res_d   = '{match: 1'b0, occurrences: cnt_q, final_res: 1'b0, error: 1'b1};
                state_d = ST_DONE;
              end else begin
                k_d     = '0;
                fbn_d   = fb_q;
                state_d = ST_SWEEP;
              end
            end
            CMD_TEXT: begin
              mem_rd_en_o = 1'b1;
              state_d     = ST_LOOK;
            end
            default: begin
              res_d   = '{match: 1'b0, occurrences: cnt_q, final_res: 1'b0, error: 1'b0};
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_LOOK: begin
        res_valid_o = 1'b1;
        res_o       = '{match: hit, occurrences: cnt_inc, final_res: last_q, error: 1'b0};
        if (res_ready_i) begin
          if (last_q) begin
            ms_d  = '0;
            cnt_d = '0;
          end else begin
            ms_d  = hit ? '0 : RW'(ns);
            cnt_d = cnt_inc;
          end
          state_d = ST_IDLE;
        end
      end

      // Copy the fallback row into the new row: read column k, write column k-1, and
      // write len+1 in the appended symbol's column. Read and write never collide.
      ST_SWEEP: begin
        if (k_q < SWEEP_END) begin
          mem_rd_en_o = 1'b1;
          rd_row      = fb_q;
          rd_col      = CW'(k_q);
        end
        if (k_q != '0) begin
          mem_wr_en_o = 1'b1;
          if (wr_col == CW'(sym_q)) begin
            mem_wr_data_o = len_q + 1'b1;
            if (len_q != '0) begin
              fbn_d = RW'(mem_rd_data_i);
            end
          end else begin
            mem_wr_data_o = (len_q == '0) ? '0 : mem_rd_data_i;
          end
        end
        if (k_q == SWEEP_END) begin
          len_d   = len_q + 1'b1;
          fb_d    = fbn_d;
          res_d   = '{match: 1'b0, occurrences: cnt_q, final_res: 1'b0, error: 1'b0};
          state_d = ST_DONE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign mem_rd_addr_o = AW'(rd_row) * ROW_STRIDE + AW'(rd_col);
  assign mem_wr_addr_o = AW'(wr_row) * ROW_STRIDE + AW'(wr_col);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      len_q    <= '0;
      fb_q     <= '0;
      fbn_q    <= '0;
      ms_q     <= '0;
      cnt_q    <= '0;
      k_q      <= '0;
      sym_q    <= '0;
      sym_ok_q <= 1'b0;
      last_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      fb_q     <= fb_d;
      fbn_q    <= fbn_d;
      ms_q     <= ms_d;
      cnt_q    <= cnt_d;
      k_q      <= k_d;
      sym_q    <= sym_d;
      sym_ok_q <= sym_ok_d;
      last_q   <= last_d;
      res_q    <= res_d;
    end
  end

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_rd_en_o && mem_wr_en_o) |-> (mem_rd_addr_o != mem_wr_addr_o))
    else $error("table read and write hit the same entry");

  a_match_state_in_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ms_q == '0) || (SVW'(ms_q) < len_q))
    else $error("match state beyond pattern length");

  a_fallback_in_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fb_q == '0) || (SVW'(fb_q) < len_q))
    else $error("fallback state beyond pattern length");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_FULL)
    else $error("pattern length beyond capacity");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && k_q == SWEEP_END) |=> (state_q == ST_DONE && $past(len_q) + 1'b1 == len_q))
    else $error("row copy did not finish with a longer pattern");

endmodule

`default_nettype wire

// ===== rtl/core/dfa_pattern_occurrence_counter_top.sv =====
`default_nettype none

// Counts non-overlapping occurrences of a pattern in a text with a KMP string-matching
// automaton whose next-state table sits in one synchronous memory of
// MAX_PATTERN x ALPHABET_SIZE entries. Append a pattern symbol per beat (command 1),
// then stream text symbols (command 2); each beat returns one result beat, and the
// text beat flagged last_of_text reports the final count and starts a fresh text.
// A text beat reads the current state's row in the accept cycle; the memory read is
// registered and the next step needs its result. An append copies the fallback row
// into the new row one entry per cycle through the memory's single write port;
// clear, a rejected append and unused commands go straight to their result. The
// table needs no clearing pass after reset. A result waits in an output register,
// so the block returns to accepting beats while the previous result is still
// unclaimed.
module dfa_pattern_occurrence_counter_top #(
  parameter int MAX_PATTERN   = 64,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [dpoc_pkg::CMD_W-1:0] command_i,
  input  logic [dpoc_pkg::SYM_W-1:0] symbol_i,
  input  logic                       last_of_text_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       match_o,
  output logic [dpoc_pkg::CNT_W-1:0] occurrences_o,
  output logic                       final_res_o,
  output logic                       error_o
);

  import dpoc_pkg::*;

  localparam int SVW   = $clog2(MAX_PATTERN + 1);
  localparam int DEPTH = MAX_PATTERN * ALPHABET_SIZE;
  localparam int AW    = $clog2(DEPTH);

  logic           res_valid;
  logic           res_ready;
  res_t           res;
  logic           mem_rd_en;
  logic [AW-1:0]  mem_rd_addr;
  logic [SVW-1:0] mem_rd_data;
  logic           mem_wr_en;
  logic [AW-1:0]  mem_wr_addr;
  logic [SVW-1:0] mem_wr_data;

  logic           out_valid_q, out_valid_d;
  res_t           out_res_q, out_res_d;

  dpoc_ctrl #(
    .MAX_PATTERN   (MAX_PATTERN),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .SVW           (SVW),
    .AW            (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .symbol_i       (symbol_i),
    .last_of_text_i (last_of_text_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .mem_rd_en_o    (mem_rd_en),
    .mem_rd_addr_o  (mem_rd_addr),
    .mem_rd_data_i  (mem_rd_data),
    .mem_wr_en_o    (mem_wr_en),
    .mem_wr_addr_o  (mem_wr_addr),
    .mem_wr_data_o  (mem_wr_data)
  );

  dpoc_table #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (SVW)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_res_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign match_o       = out_res_q.match;
  assign occurrences_o = out_res_q.occurrences;
  assign final_res_o   = out_res_q.final_res;
  assign error_o       = out_res_q.error;

endmodule

`default_nettype wire
